// File: design/rpe_pkg.sv
// Shared types, constants and constant functions for the radial profile evaluator.
// Used by every module of the block; depends on nothing else.
package rpe_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int RADIUS_W = 24;
    localparam int VALUE_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA = 2'd2;

    // Profile modes
    localparam logic [1:0] MODE_SERSIC = 2'd0;
    localparam logic [1:0] MODE_EXP    = 2'd1;
    localparam logic [1:0] MODE_DEV    = 2'd2;

    localparam logic [1:0]  MODE_RST  = MODE_SERSIC;
    localparam logic [17:0] INV_RST   = 18'd65536;
    localparam logic [19:0] KAPPA_RST = 20'd109992;

    // Q.32 constants
    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] CAP_Q32   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LOG2E_Q32 = 64'h0000_0001_7154_7652;
    localparam logic [63:0] LUX_FAC_Q32 = (64'd167835 << 32) / 64'd100000;
    localparam logic [63:0] LUV_FAC_Q32 = (64'd766925 << 32) / 64'd100000;
    localparam logic [63:0] SOFT_Q32    = (64'd4 << 32) / 64'd10000;
    localparam logic [63:0] EIGHTH_Q32  = 64'h0000_0000_2000_0000;

    // Source of the value that enters the exponential stage
    typedef enum logic [1:0] {
        T_POW,
        T_RQ,
        T_ZERO,
        T_ONE
    } tsel_t;

    // Per-item context carried along the pipeline
    typedef struct packed {
        logic        zero;
        tsel_t       tsel;
        logic        lneg;
        logic        eneg;
        logic [32:0] w;
        logic [63:0] rq;
    } ctx_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bq;
        rem = v;
        res = '0;
        bq  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bq > rem) bq = bq >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bq != 0) begin
                if (rem >= res + bq) begin
                    rem = rem - (res + bq);
                    res = (res >> 1) + bq;
                end
                else begin
                    res = res >> 1;
                end
                bq = bq >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q.31, by repeated square roots from 2.0
    function automatic logic [31:0] pow2_root(input int k);
        logic [63:0] r;
        r = ONE_Q32;
        for (int j = 1; j <= 32; j++) begin
            if (j <= k) r = isqrt64(r << 31);
        end
        return r[31:0];
    endfunction

endpackage

// File: design/rpe_mul.sv
// Pipelined Q.32 multiplier, floor(a*b/2^32) clamped at 2^62, two stages.
// Depends on rpe_pkg for the context type and the clamp constant.
module rpe_mul import rpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        in_ctx,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        out_valid,
    output ctx_t        out_ctx,
    output logic [63:0] p
);

    logic [63:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic        v1_reg;
    ctx_t        c1_reg;
    logic [63:0] p_reg;
    logic        v2_reg;
    ctx_t        c2_reg;
    logic [97:0] sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= {32'b0, a[63:32]} * {32'b0, b[63:32]};
            hl_reg <= {32'b0, a[63:32]} * {32'b0, b[31:0]};
            lh_reg <= {32'b0, a[31:0]} * {32'b0, b[63:32]};
            ll_reg <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
            c1_reg <= in_ctx;
            p_reg  <= (sum[97:62] != '0) ? CAP_Q32 : sum[63:0];
            c2_reg <= c1_reg;
        end
    end

    assign sum = {2'b0, hh_reg, 32'b0} + {34'b0, hl_reg} + {34'b0, lh_reg}
               + {66'b0, ll_reg[63:32]};

    assign out_valid = v2_reg;
    assign out_ctx   = c2_reg;
    assign p         = p_reg;

endmodule

// File: design/rpe_log2.sv
// Pipelined log2 of a Q.32 value: normalize over two stages, then one squaring
// stage per fraction bit. Depends on rpe_pkg for the context type.
module rpe_log2 import rpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        in_ctx,
    input  logic [63:0] x,
    output logic        out_valid,
    output ctx_t        out_ctx,
    output logic        neg,
    output logic [63:0] mag
);

    localparam int STEPS = 32;

    logic [63:0] x1_reg;
    logic [5:0]  p1_reg;
    logic        v1_reg;
    ctx_t        c1_reg;

    logic [31:0] m_reg   [0:STEPS];
    logic [31:0] f_reg   [0:STEPS];
    logic [5:0]  p_reg   [0:STEPS];
    logic        vld_reg [0:STEPS];
    ctx_t        ctx_reg [0:STEPS];

    logic        neg_reg;
    logic [63:0] mag_reg;
    logic        vo_reg;
    ctx_t        co_reg;

    logic [5:0]  msb;
    logic [63:0] norm;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i]) msb = 6'(i);
        end
    end

    always_comb
    begin
        if (p1_reg >= 6'd31) norm = x1_reg >> (p1_reg - 6'd31);
        else                 norm = x1_reg << (6'd31 - p1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            vld_reg[0] <= 1'b0;
            vo_reg     <= 1'b0;
        end
        else if (en)
        begin
            v1_reg     <= in_valid;
            vld_reg[0] <= v1_reg;
            vo_reg     <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= x;
            p1_reg     <= msb;
            c1_reg     <= in_ctx;
            m_reg[0]   <= norm[31:0];
            f_reg[0]   <= '0;
            p_reg[0]   <= p1_reg;
            ctx_reg[0] <= c1_reg;
            co_reg     <= ctx_reg[STEPS];
            if (p_reg[STEPS] >= 6'd32)
            begin
                neg_reg <= 1'b0;
                mag_reg <= {26'b0, 6'(p_reg[STEPS] - 6'd32), f_reg[STEPS]};
            end
            else
            begin
                neg_reg <= 1'b1;
                mag_reg <= {26'b0, 6'(6'd32 - p_reg[STEPS]), 32'b0}
                         - {32'b0, f_reg[STEPS]};
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] m2;

        assign sq = {32'b0, m_reg[k-1]} * {32'b0, m_reg[k-1]};
        assign m2 = sq[63:31];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)   vld_reg[k] <= 1'b0;
            else if (en)  vld_reg[k] <= vld_reg[k-1];
        end

        // square, and renormalize when the square reaches 2
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]   <= m2[32] ? m2[32:1] : m2[31:0];
                f_reg[k]   <= f_reg[k-1] | ({31'b0, m2[32]} << (STEPS - k));
                p_reg[k]   <= p_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_ctx   = co_reg;
    assign neg       = neg_reg;
    assign mag       = mag_reg;

endmodule

// File: design/rpe_pow2.sv
// Pipelined 2^(+/-mag) for a Q.32 magnitude: one setup stage, one stage per
// fraction bit multiplying in a constant root, one shift stage. Uses rpe_pkg.
module rpe_pow2 import rpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  ctx_t        in_ctx,
    input  logic        neg,
    input  logic [63:0] mag,
    output logic        out_valid,
    output ctx_t        out_ctx,
    output logic [63:0] y
);

    localparam int STEPS = 32;

    logic [31:0] acc_reg [0:STEPS];
    logic [31:0] g_reg   [0:STEPS];
    logic        neg_reg [0:STEPS];
    logic        cap_reg [0:STEPS];
    logic        zro_reg [0:STEPS];
    logic [5:0]  sh_reg  [0:STEPS];
    logic        vld_reg [0:STEPS];
    ctx_t        ctx_reg [0:STEPS];

    logic [63:0] y_reg;
    logic        vo_reg;
    ctx_t        co_reg;

    logic [31:0] ipart;
    logic [31:0] fpart;
    logic [32:0] e_n;
    logic [31:0] g_n;
    logic        cap_n;
    logic        zro_n;
    logic [5:0]  sh_n;

    assign ipart = mag[63:32];
    assign fpart = mag[31:0];

    always_comb
    begin
        cap_n = 1'b0;
        zro_n = 1'b0;
        e_n   = {1'b0, ipart};
        g_n   = fpart;
        if (!neg)
        begin
            cap_n = (ipart >= 32'd30);
            sh_n  = 6'(ipart[4:0]) + 6'd1;
        end
        else
        begin
            if (fpart == '0)
            begin
                e_n = {1'b0, ipart};
                g_n = '0;
            end
            else
            begin
                e_n = {1'b0, ipart} + 33'd1;
                g_n = 32'd0 - fpart;
            end
            zro_n = (e_n >= 33'd64);
            sh_n  = e_n[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vo_reg     <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            vo_reg     <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0] <= 32'h8000_0000;
            g_reg[0]   <= g_n;
            neg_reg[0] <= neg;
            cap_reg[0] <= cap_n;
            zro_reg[0] <= zro_n;
            sh_reg[0]  <= sh_n;
            ctx_reg[0] <= in_ctx;
            co_reg     <= ctx_reg[STEPS];
            if (!neg_reg[STEPS])
            begin
                if (cap_reg[STEPS]) y_reg <= CAP_Q32;
                else                y_reg <= {32'b0, acc_reg[STEPS]} << sh_reg[STEPS];
            end
            else
            begin
                if (zro_reg[STEPS]) y_reg <= '0;
                else y_reg <= {31'b0, acc_reg[STEPS], 1'b0} >> sh_reg[STEPS];
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_fr
        localparam logic [31:0] ROOT = pow2_root(k);
        logic [63:0] prod;

        assign prod = {32'b0, acc_reg[k-1]} * {32'b0, ROOT};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)   vld_reg[k] <= 1'b0;
            else if (en)  vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= g_reg[k-1][STEPS-k] ? prod[62:31] : acc_reg[k-1];
                g_reg[k]   <= g_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                cap_reg[k] <= cap_reg[k-1];
                zro_reg[k] <= zro_reg[k-1];
                sh_reg[k]  <= sh_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_ctx   = co_reg;
    assign y         = y_reg;

endmodule

// File: design/radial_profile_evaluate.sv
// Radial profile evaluator top level: config registers, pipeline glue, output stage.
// Depends on rpe_pkg, rpe_mul, rpe_log2 and rpe_pow2.
//
//   channel  | direction | signals                          | word
//   s_*      | in        | s_tvalid s_tready s_tdata        | radius
//   m_*      | out       | m_tvalid m_tready m_tdata m_tuser| profile value, saturated flag
//   cfg_*    | in        | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// One radius enters per cycle while m_tready does not hold the output word. Most of the
// pipeline lies in the two exp2 units and the log2 unit, 32 multiply stages each.
// When the output word is held by m_tready, the whole pipeline freezes with it.
// Reset clears the valid bits and loads the register defaults; cfg_ready is always high.
module radial_profile_evaluate import rpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RADIUS_W-1:0]   s_tdata,   // [23:0] radius
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_W-1:0]    m_tdata,   // [31:0] profile_value
    output logic                  m_tuser,   // [0] saturated
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SHIFT = 32 - FRAC_BITS;

    logic [1:0]  mode_reg;
    logic [17:0] inv_reg;
    logic [19:0] kappa_reg;

    logic        en;
    logic [63:0] iiq;
    logic [63:0] kq;

    // entry
    logic [63:0] rq_n;
    ctx_t        ctx_n;
    logic [32:0] s_n;
    logic        e_vld_reg;
    logic [63:0] e_rq_reg;
    logic [32:0] e_s_reg;
    ctx_t        e_ctx_reg;

    logic        a_vld;
    ctx_t        a_ctx;
    logic [63:0] a_p;
    logic [63:0] t1_p;

    logic        x_vld_reg;
    logic [63:0] x_reg;
    ctx_t        x_ctx_reg;
    ctx_t        x_ctx_next;

    logic        l_vld;
    ctx_t        l_ctx;
    logic        l_neg;
    logic [63:0] l_mag;
    ctx_t        lb_ctx;
    logic [63:0] mb_b;

    logic        b_vld;
    ctx_t        b_ctx;
    logic [63:0] b_p;

    logic        q_vld;
    ctx_t        q_ctx;
    logic [63:0] q_val;

    logic [63:0] t_sel;
    logic        d_vld_reg;
    logic [63:0] d_reg;
    ctx_t        d_ctx_reg;
    logic [63:0] d_next;
    ctx_t        d_ctx_next;
    logic [63:0] fac;

    logic        c_vld;
    ctx_t        c_ctx;
    logic [63:0] c_p;
    logic [63:0] t2_p;
    ctx_t        cw_ctx;

    logic        dd_vld;
    ctx_t        dd_ctx;
    logic [63:0] dd_p;

    logic        v_vld;
    ctx_t        v_ctx;
    logic [63:0] v_val;

    logic        f_vld;
    ctx_t        f_ctx;
    logic [63:0] f_p;
    logic [63:0] raw;

    logic        o_vld_reg;
    logic [31:0] o_data_reg;
    logic        o_sat_reg;

    assign en        = !o_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign iiq = 64'(inv_reg) << SHIFT;
    assign kq  = 64'(kappa_reg) << SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RST;
            inv_reg   <= INV_RST;
            kappa_reg <= KAPPA_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_INV:   inv_reg   <= cfg_data[17:0];
                REG_KAPPA: kappa_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // classify the radius for the selected profile
    always_comb
    begin
        rq_n       = 64'(s_tdata) << SHIFT;
        ctx_n      = '0;
        ctx_n.rq   = rq_n;
        ctx_n.tsel = T_ONE;
        s_n        = '0;
        case (mode_reg)
            MODE_SERSIC:
            begin
                if (kappa_reg == '0 || inv_reg == '0) ctx_n.tsel = T_ONE;
                else if (rq_n == '0)                  ctx_n.tsel = T_ZERO;
                else                                  ctx_n.tsel = T_POW;
            end
            MODE_EXP:
            begin
                ctx_n.tsel = T_RQ;
                ctx_n.zero = (rq_n > 64'(4) * ONE_Q32);
                if (rq_n > 64'(3) * ONE_Q32) s_n = 33'(rq_n - 64'(3) * ONE_Q32);
            end
            MODE_DEV:
            begin
                ctx_n.tsel = T_POW;
                ctx_n.zero = (rq_n > 64'(8) * ONE_Q32);
                if (rq_n > 64'(7) * ONE_Q32) s_n = 33'(rq_n - 64'(7) * ONE_Q32);
            end
            default: ctx_n.zero = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            x_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= s_tvalid;
            x_vld_reg <= a_vld;
            d_vld_reg <= q_vld;
            o_vld_reg <= f_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_rq_reg  <= rq_n;
            e_s_reg   <= s_n;
            e_ctx_reg <= ctx_n;
        end
    end

    rpe_mul u_mul_sq (
        .clk, .rst_n, .en,
        .in_valid (e_vld_reg), .in_ctx (e_ctx_reg),
        .a (e_rq_reg), .b (e_rq_reg),
        .out_valid (a_vld), .out_ctx (a_ctx), .p (a_p)
    );

    rpe_mul u_mul_ts (
        .clk, .rst_n, .en,
        .in_valid (e_vld_reg), .in_ctx (e_ctx_reg),
        .a ({31'b0, e_s_reg}), .b ({31'b0, e_s_reg}),
        .out_valid (), .out_ctx (), .p (t1_p)
    );

    // log2 argument and first taper factor
    always_comb
    begin
        x_ctx_next   = a_ctx;
        x_ctx_next.w = ONE_Q32[32:0] - t1_p[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= (mode_reg == MODE_DEV) ? a_p + SOFT_Q32 : a_ctx.rq;
            x_ctx_reg <= x_ctx_next;
        end
    end

    rpe_log2 u_log2 (
        .clk, .rst_n, .en,
        .in_valid (x_vld_reg), .in_ctx (x_ctx_reg), .x (x_reg),
        .out_valid (l_vld), .out_ctx (l_ctx), .neg (l_neg), .mag (l_mag)
    );

    always_comb
    begin
        lb_ctx      = l_ctx;
        lb_ctx.lneg = l_neg;
    end

    assign mb_b = (mode_reg == MODE_SERSIC) ? iiq : EIGHTH_Q32;

    rpe_mul u_mul_pw (
        .clk, .rst_n, .en,
        .in_valid (l_vld), .in_ctx (lb_ctx),
        .a (l_mag), .b (mb_b),
        .out_valid (b_vld), .out_ctx (b_ctx), .p (b_p)
    );

    rpe_pow2 u_pow2_root (
        .clk, .rst_n, .en,
        .in_valid (b_vld), .in_ctx (b_ctx), .neg (b_ctx.lneg), .mag (b_p),
        .out_valid (q_vld), .out_ctx (q_ctx), .y (q_val)
    );

    always_comb
    begin
        case (q_ctx.tsel)
            T_POW:   t_sel = q_val;
            T_RQ:    t_sel = q_ctx.rq;
            T_ZERO:  t_sel = '0;
            default: t_sel = ONE_Q32;
        endcase
    end

    // distance from one and the sign of the exponent
    always_comb
    begin
        d_ctx_next = q_ctx;
        if (t_sel >= ONE_Q32)
        begin
            d_next          = t_sel - ONE_Q32;
            d_ctx_next.eneg = 1'b1;
        end
        else
        begin
            d_next          = ONE_Q32 - t_sel;
            d_ctx_next.eneg = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg     <= d_next;
            d_ctx_reg <= d_ctx_next;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SERSIC: fac = kq;
            MODE_EXP:    fac = LUX_FAC_Q32;
            default:     fac = LUV_FAC_Q32;
        endcase
    end

    rpe_mul u_mul_fac (
        .clk, .rst_n, .en,
        .in_valid (d_vld_reg), .in_ctx (d_ctx_reg),
        .a (d_reg), .b (fac),
        .out_valid (c_vld), .out_ctx (c_ctx), .p (c_p)
    );

    rpe_mul u_mul_tw (
        .clk, .rst_n, .en,
        .in_valid (d_vld_reg), .in_ctx (d_ctx_reg),
        .a ({31'b0, d_ctx_reg.w}), .b ({31'b0, d_ctx_reg.w}),
        .out_valid (), .out_ctx (), .p (t2_p)
    );

    always_comb
    begin
        cw_ctx   = c_ctx;
        cw_ctx.w = t2_p[32:0];
    end

    rpe_mul u_mul_l2e (
        .clk, .rst_n, .en,
        .in_valid (c_vld), .in_ctx (cw_ctx),
        .a (c_p), .b (LOG2E_Q32),
        .out_valid (dd_vld), .out_ctx (dd_ctx), .p (dd_p)
    );

    rpe_pow2 u_pow2_exp (
        .clk, .rst_n, .en,
        .in_valid (dd_vld), .in_ctx (dd_ctx), .neg (dd_ctx.eneg), .mag (dd_p),
        .out_valid (v_vld), .out_ctx (v_ctx), .y (v_val)
    );

    // apply taper (weight is one outside the taper band)
    rpe_mul u_mul_tp (
        .clk, .rst_n, .en,
        .in_valid (v_vld), .in_ctx (v_ctx),
        .a (v_val), .b ({31'b0, v_ctx.w}),
        .out_valid (f_vld), .out_ctx (f_ctx), .p (f_p)
    );

    assign raw = f_p >> SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (f_ctx.zero)
            begin
                o_data_reg <= '0;
                o_sat_reg  <= 1'b0;
            end
            else if (raw[63:32] != '0)
            begin
                o_data_reg <= '1;
                o_sat_reg  <= 1'b1;
            end
            else
            begin
                o_data_reg <= raw[31:0];
                o_sat_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_sat_reg;

endmodule
